FILE: sv/lap_stopwatch_macros.svh
// Assertion macros for the lap stopwatch.
`ifndef LAP_STOPWATCH_MACROS_SVH
`define LAP_STOPWATCH_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication check.
`define LSW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// Next-cycle implication check.
`define LSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define LSW_ASSERT_IMP(label, clk, rst, ante, cons)
`define LSW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/lsw_pkg.sv
// Shared constants, codes and types of the lap stopwatch.
`timescale 1ns / 1ps
`default_nettype none
package lsw_pkg;

   localparam int MAX_LAPS  = 15;
   localparam int VIEW_ROWS = 3;
   localparam int ADDR_W    = $clog2(MAX_LAPS);

   localparam int CNT_W   = 4;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int FRAC_W  = 7;
   localparam int PHASE_W = 5;

   localparam int PHASE_STEP  = 2;
   localparam int PHASE_MOD   = 32;
   localparam int FRAC_MULT   = 3;
   localparam int SEC_PER_MIN = 60;
   localparam int MIN_LIMIT   = 60;
   localparam int FRAC_BASE   = 100;

   // action codes
   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_ENTER = 3'd1;
   localparam logic [2:0] ACT_UP    = 3'd2;
   localparam logic [2:0] ACT_DOWN  = 3'd3;
   localparam logic [2:0] ACT_EXIT  = 3'd4;
   localparam logic [2:0] ACT_CLEAR = 3'd5;
   localparam logic [2:0] ACT_READ  = 3'd6;

   // mode codes
   localparam logic [1:0] MODE_RUN   = 2'd0;
   localparam logic [1:0] MODE_STOP  = 2'd1;
   localparam logic [1:0] MODE_INIT  = 2'd2;
   localparam logic [1:0] MODE_CLOSE = 2'd3;

   typedef struct packed {
      logic [MIN_W-1:0]  m;
      logic [SEC_W-1:0]  s;
      logic [FRAC_W-1:0] f;
   } stamp_type;

   localparam int STAMP_W = $bits(stamp_type);

   // one request after the state update, handed to the lap stage
   typedef struct packed {
      logic [1:0]        mode;
      logic [MIN_W-1:0]  minutes;
      logic [SEC_W-1:0]  seconds;
      logic [FRAC_W-1:0] fraction;
      logic [CNT_W-1:0]  lap_count;
      logic [CNT_W-1:0]  view_top;
      stamp_type         now;
      logic              store;
      logic              read;
      logic              has_prev;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_addr;
   } item_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      stamp_type         lap;
      stamp_type         split;
   } wr_type;

   localparam int REQ_W = 8;
   localparam int RSP_W = 72;

   typedef struct packed {
      logic             pad;
      logic [CNT_W-1:0] lap_index;
      logic [2:0]       action;
   } req_type;

   typedef struct packed {
      logic [4:0]        pad;
      logic [FRAC_W-1:0] split_fraction;
      logic [SEC_W-1:0]  split_seconds;
      logic [MIN_W-1:0]  split_minutes;
      logic [FRAC_W-1:0] lap_fraction;
      logic [SEC_W-1:0]  lap_seconds;
      logic [MIN_W-1:0]  lap_minutes;
      logic [CNT_W-1:0]  view_top;
      logic [CNT_W-1:0]  lap_count;
      logic [FRAC_W-1:0] fraction;
      logic [SEC_W-1:0]  seconds;
      logic [MIN_W-1:0]  minutes;
      logic [1:0]        mode;
   } rsp_type;

endpackage
`default_nettype wire

FILE: sv/lsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: sv/lsw_ctrl.sv
// Scalar watch state: counters, mode, lap count and view window.
`timescale 1ns / 1ps
`default_nettype none
module lsw_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [2:0]         action,
   input  wire logic [lsw_pkg::CNT_W-1:0] lap_index,
   output lsw_pkg::item_type       item
);

   logic [1:0]                   mode_ff,  mode_in;
   logic [lsw_pkg::MIN_W-1:0]    min_ff,   min_in;
   logic [lsw_pkg::SEC_W-1:0]    sec_ff,   sec_in;
   logic [lsw_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [lsw_pkg::CNT_W-1:0]    laps_ff,  laps_in;
   logic [lsw_pkg::CNT_W-1:0]    top_ff,   top_in;

   logic [lsw_pkg::PHASE_W:0]    ph_sum;
   logic [lsw_pkg::SEC_W-1:0]    sec_inc;
   logic [lsw_pkg::MIN_W-1:0]    min_inc;
   logic [lsw_pkg::CNT_W:0]      laps_inc;
   logic [lsw_pkg::CNT_W:0]      laps_after;
   logic [lsw_pkg::CNT_W:0]      view_end;
   logic                         store;
   logic                         read;
   logic [1:0]                   mode_out;

   always_comb begin
      mode_in  = mode_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      phase_in = phase_ff;
      laps_in  = laps_ff;
      top_in   = top_ff;
      store    = 1'b0;
      read     = 1'b0;

      ph_sum     = {1'b0, phase_ff} + (lsw_pkg::PHASE_W+1)'(lsw_pkg::PHASE_STEP);
      sec_inc    = sec_ff + 1'b1;
      min_inc    = min_ff + 1'b1;
      laps_inc   = {1'b0, laps_ff} + 1'b1;
      view_end   = {1'b0, top_ff} + (lsw_pkg::CNT_W+1)'(lsw_pkg::VIEW_ROWS);
      laps_after = {1'b0, laps_ff};

      case (action)
         lsw_pkg::ACT_TICK: begin
            if (mode_ff == lsw_pkg::MODE_RUN) begin
               phase_in = ph_sum[lsw_pkg::PHASE_W-1:0];
               if (ph_sum >= (lsw_pkg::PHASE_W+1)'(lsw_pkg::PHASE_MOD)) begin
                  if (sec_inc >= lsw_pkg::SEC_W'(lsw_pkg::SEC_PER_MIN)) begin
                     sec_in = '0;
                     min_in = min_inc;
                     if (min_inc >= lsw_pkg::MIN_W'(lsw_pkg::MIN_LIMIT)) begin
                        min_in  = lsw_pkg::MIN_W'(lsw_pkg::MIN_LIMIT);
                        mode_in = lsw_pkg::MODE_STOP;
                     end
                  end else begin
                     sec_in = sec_inc;
                  end
               end
            end
         end
         lsw_pkg::ACT_ENTER: begin
            if (mode_ff != lsw_pkg::MODE_RUN) begin
               mode_in  = lsw_pkg::MODE_RUN;
               min_in   = '0;
               sec_in   = '0;
               phase_in = '0;
               laps_in  = '0;
               top_in   = '0;
            end else begin
               if ({1'b0, laps_ff} < (lsw_pkg::CNT_W+1)'(lsw_pkg::MAX_LAPS)) begin
                  store      = 1'b1;
                  laps_in    = laps_inc[lsw_pkg::CNT_W-1:0];
                  laps_after = laps_inc;
                  // keep the newest lap inside the view window
                  if ((view_end + 1'b1 == laps_inc) &&
                      (laps_inc > (lsw_pkg::CNT_W+1)'(lsw_pkg::VIEW_ROWS))) begin
                     top_in = top_ff + 1'b1;
                  end
               end
               if (laps_after >= (lsw_pkg::CNT_W+1)'(lsw_pkg::MAX_LAPS)) begin
                  mode_in = lsw_pkg::MODE_STOP;
               end
            end
         end
         lsw_pkg::ACT_UP: begin
            if (top_ff != '0) begin
               top_in = top_ff - 1'b1;
            end
         end
         lsw_pkg::ACT_DOWN: begin
            if (view_end < {1'b0, laps_ff}) begin
               top_in = top_ff + 1'b1;
            end
         end
         lsw_pkg::ACT_CLEAR: begin
            mode_in  = lsw_pkg::MODE_INIT;
            min_in   = '0;
            sec_in   = '0;
            phase_in = '0;
            laps_in  = '0;
            top_in   = '0;
         end
         lsw_pkg::ACT_READ: begin
            if ((lap_index < laps_ff) &&
                ({1'b0, lap_index} < (lsw_pkg::CNT_W+1)'(lsw_pkg::MAX_LAPS))) begin
               read = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // exit: stop, or report a close request when already stopped
      mode_out = mode_in;
      if (action == lsw_pkg::ACT_EXIT) begin
         if (mode_in == lsw_pkg::MODE_STOP) begin
            mode_out = lsw_pkg::MODE_CLOSE;
         end else begin
            mode_in  = lsw_pkg::MODE_STOP;
            mode_out = lsw_pkg::MODE_STOP;
         end
      end

      item.mode      = mode_out;
      item.minutes   = min_in;
      item.seconds   = sec_in;
      item.fraction  = lsw_pkg::FRAC_W'(phase_in) * lsw_pkg::FRAC_W'(lsw_pkg::FRAC_MULT);
      item.lap_count = laps_in;
      item.view_top  = top_in;
      item.now.m     = min_ff;
      item.now.s     = sec_ff;
      item.now.f     = lsw_pkg::FRAC_W'(phase_ff) * lsw_pkg::FRAC_W'(lsw_pkg::FRAC_MULT);
      item.store     = store;
      item.read      = read;
      item.has_prev  = (laps_ff != '0);
      item.wr_addr   = lsw_pkg::ADDR_W'(laps_ff);
      item.rd_addr   = store ? lsw_pkg::ADDR_W'(laps_ff - 1'b1)
                             : lsw_pkg::ADDR_W'(lap_index);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= lsw_pkg::MODE_INIT;
         min_ff   <= '0;
         sec_ff   <= '0;
         phase_ff <= '0;
         laps_ff  <= '0;
         top_ff   <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
         phase_ff <= phase_in;
         laps_ff  <= laps_in;
         top_ff   <= top_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/lsw_split.sv
// Lap stage: memory read-back with forwarding, split math, store and result register.
`timescale 1ns / 1ps
`default_nettype none
module lsw_split (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire lsw_pkg::item_type   item,
   input  wire lsw_pkg::stamp_type  rd_lap,
   input  wire lsw_pkg::stamp_type  rd_split,
   input  wire logic                rsp_ready,
   output logic                     ready,
   output lsw_pkg::wr_type          wr,
   output logic                     rsp_valid,
   output lsw_pkg::rsp_type         rsp_data
);

   logic                s1_valid_ff, s1_valid_in;
   lsw_pkg::item_type   s1_ff;
   logic                fwd_ff, fwd_in;
   lsw_pkg::stamp_type  fwd_lap_ff;
   lsw_pkg::stamp_type  fwd_split_ff;
   logic                out_valid_ff, out_valid_in;
   lsw_pkg::rsp_type    out_ff, out_in;

   logic                s1_go;
   lsw_pkg::stamp_type  prev_lap;
   lsw_pkg::stamp_type  prev_split;
   lsw_pkg::stamp_type  diff;
   lsw_pkg::stamp_type  lap_out;
   lsw_pkg::stamp_type  split_out;
   logic [lsw_pkg::FRAC_W:0] df;
   logic [lsw_pkg::SEC_W:0]  ds;
   logic [lsw_pkg::MIN_W:0]  dm;

   assign s1_go = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign ready = !s1_valid_ff || s1_go;

   always_comb begin
      // entry written by the item ahead in the same cycle comes from the forward copy
      prev_lap   = fwd_ff ? fwd_lap_ff   : rd_lap;
      prev_split = fwd_ff ? fwd_split_ff : rd_split;

      df = {1'b0, s1_ff.now.f} - {1'b0, prev_lap.f};
      ds = {1'b0, s1_ff.now.s} - {1'b0, prev_lap.s} - (lsw_pkg::SEC_W+1)'(df[lsw_pkg::FRAC_W]);
      dm = {1'b0, s1_ff.now.m} - {1'b0, prev_lap.m} - (lsw_pkg::MIN_W+1)'(ds[lsw_pkg::SEC_W]);

      diff = '0;
      if (s1_ff.has_prev) begin
         diff.f = df[lsw_pkg::FRAC_W] ?
                  lsw_pkg::FRAC_W'(df + (lsw_pkg::FRAC_W+1)'(lsw_pkg::FRAC_BASE)) :
                  df[lsw_pkg::FRAC_W-1:0];
         diff.s = ds[lsw_pkg::SEC_W] ?
                  lsw_pkg::SEC_W'(ds + (lsw_pkg::SEC_W+1)'(lsw_pkg::SEC_PER_MIN)) :
                  ds[lsw_pkg::SEC_W-1:0];
         diff.m = dm[lsw_pkg::MIN_W] ? '0 : dm[lsw_pkg::MIN_W-1:0];
      end

      wr.en    = s1_go && s1_ff.store;
      wr.addr  = s1_ff.wr_addr;
      wr.lap   = s1_ff.now;
      wr.split = diff;

      lap_out   = '0;
      split_out = '0;
      if (s1_ff.store) begin
         lap_out   = s1_ff.now;
         split_out = diff;
      end else if (s1_ff.read) begin
         lap_out   = prev_lap;
         split_out = prev_split;
      end

      out_in.pad            = '0;
      out_in.mode           = s1_ff.mode;
      out_in.minutes        = s1_ff.minutes;
      out_in.seconds        = s1_ff.seconds;
      out_in.fraction       = s1_ff.fraction;
      out_in.lap_count      = s1_ff.lap_count;
      out_in.view_top       = s1_ff.view_top;
      out_in.lap_minutes    = lap_out.m;
      out_in.lap_seconds    = lap_out.s;
      out_in.lap_fraction   = lap_out.f;
      out_in.split_minutes  = split_out.m;
      out_in.split_seconds  = split_out.s;
      out_in.split_fraction = split_out.f;

      s1_valid_in  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_go ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      fwd_in       = wr.en && (wr.addr == item.rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff        <= item;
         fwd_ff       <= fwd_in;
         fwd_lap_ff   <= wr.lap;
         fwd_split_ff <= wr.split;
      end
      if (s1_go) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

FILE: sv/lap_stopwatch.sv
// Top level of the lap stopwatch with lap and split memories.
//
//  channel  dir  tdata fields (low bit up)
//  req_     in   action[2:0] lap_index[6:3], zero pad to 8 bits
//  rsp_     out  mode[1:0] minutes[7:2] seconds[13:8] fraction[20:14]
//                lap_count[24:21] view_top[28:25] lap_minutes[34:29]
//                lap_seconds[40:35] lap_fraction[47:41] split_minutes[53:48]
//                split_seconds[59:54] split_fraction[66:60], zero pad to 72
//
// One request per cycle sustained while rsp_tready is high. Control state updates at
// acceptance; the lap and split memories are read then and their registered data is
// used in the lap stage, where the split is computed and a new lap written back
// (same-entry hits forwarded). A response passes the lap stage, then the output
// register; with rsp_ stalled, each of the two holds one request before req_tready
// drops. Synchronous reset clears control state; the memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "lap_stopwatch_macros.svh"
module lap_stopwatch (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [lsw_pkg::REQ_W-1:0] req_tdata,  // action, lap_index
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // mode, minutes, seconds, fraction, lap_count, view_top, lap_minutes,
   // lap_seconds, lap_fraction, split_minutes, split_seconds, split_fraction
   output logic      [lsw_pkg::RSP_W-1:0] rsp_tdata
);

   lsw_pkg::req_type    req_fields;
   lsw_pkg::rsp_type    rsp_fields;
   lsw_pkg::item_type   item;
   lsw_pkg::wr_type     wr;
   lsw_pkg::stamp_type  rd_lap;
   lsw_pkg::stamp_type  rd_split;
   logic                accept;

   assign req_fields = req_tdata;
   assign accept     = req_tvalid && req_tready;

   lsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_fields.action),
      .lap_index (req_fields.lap_index),
      .item      (item)
   );

   // lap times
   lsw_ram #(
      .WIDTH (lsw_pkg::STAMP_W),
      .DEPTH (lsw_pkg::MAX_LAPS)
   ) u_lap_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.lap),
      .rd_en   (accept),
      .rd_addr (item.rd_addr),
      .rd_data (rd_lap)
   );

   // split times, same addressing as the lap times
   lsw_ram #(
      .WIDTH (lsw_pkg::STAMP_W),
      .DEPTH (lsw_pkg::MAX_LAPS)
   ) u_split_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.split),
      .rd_en   (accept),
      .rd_addr (item.rd_addr),
      .rd_data (rd_split)
   );

   lsw_split u_split (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .rd_lap    (rd_lap),
      .rd_split  (rd_split),
      .rsp_ready (rsp_tready),
      .ready     (req_tready),
      .wr        (wr),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_fields)
   );

   assign rsp_tdata = rsp_fields;

   // the view window never starts past the last stored lap
   `LSW_ASSERT_IMP(a_view_in_range, clock, reset, rsp_tvalid,
      (rsp_fields.view_top == '0) || (rsp_fields.view_top < rsp_fields.lap_count))
   // a running watch is always below the minute limit
   `LSW_ASSERT_IMP(a_run_below_limit, clock, reset,
      rsp_tvalid && (rsp_fields.mode == lsw_pkg::MODE_RUN),
      rsp_fields.minutes < lsw_pkg::MIN_W'(lsw_pkg::MIN_LIMIT))
   // laps are only written inside the store
   `LSW_ASSERT_IMP(a_store_addr, clock, reset, wr.en,
      wr.addr < lsw_pkg::ADDR_W'(lsw_pkg::MAX_LAPS))
   // a write always produces a response in the next cycle
   `LSW_ASSERT_NEXT(a_write_responds, clock, reset, wr.en, rsp_tvalid)

endmodule
`default_nettype wire
